// ===== design/mpmac_pkg.sv =====
// Shared types and constants for the multiprecision multiply-accumulate block.
`default_nettype none

package mpmac_pkg;

  localparam int DIGIT_W   = 8;
  localparam int PROD_W    = 2 * DIGIT_W;
  localparam int LEN_W     = 6;
  localparam int POS_W     = 7;
  localparam int CFG_IDX_W = 1;

  localparam logic [POS_W-1:0]     POS_MAX   = 7'd127;
  localparam logic [LEN_W-1:0]     LEN_RESET = 6'd32;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_X_LENGTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_Y_LENGTH = 1'b1;

  typedef struct packed {
    logic [DIGIT_W-1:0] x_digit;
    logic [DIGIT_W-1:0] y_digit;
    logic [DIGIT_W-1:0] acc_digit;
    logic               load_last;
  } load_item_t;

  typedef struct packed {
    logic [DIGIT_W-1:0] result_digit;
    logic               overflow;
    logic               result_last;
  } result_item_t;

  // Broadcast control for the row of multiply cells
  typedef struct packed {
    logic               clear;
    logic               advance;
    logic [DIGIT_W-1:0] mult_digit;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== design/mpmac_cell.sv =====
// One digit cell of the multiply row: holds an x digit, a sum digit and a carry digit.
`default_nettype none

module mpmac_cell
  import mpmac_pkg::*;
(
  input  wire logic               clk,
  input  wire cell_ctrl_t         ctrl,
  input  wire logic               x_wr,
  input  wire logic [DIGIT_W-1:0] x_wr_data,
  input  wire logic               x_en,
  input  wire logic [DIGIT_W-1:0] sum_in,
  output logic      [DIGIT_W-1:0] sum_out,
  output logic                    nonzero
);

  logic [DIGIT_W-1:0] x_digit;
  logic [DIGIT_W-1:0] sum;
  logic [DIGIT_W-1:0] carry;
  logic [DIGIT_W-1:0] x_eff;
  logic [PROD_W-1:0]  total;

  // Digits above the active multiplicand length count as zero.
  assign x_eff = x_en ? x_digit : '0;
  assign total = PROD_W'(x_eff) * PROD_W'(ctrl.mult_digit)
               + PROD_W'(sum) + PROD_W'(carry);

  assign sum_out = total[DIGIT_W-1:0];
  assign nonzero = (sum != '0) || (carry != '0);

  always_ff @(posedge clk) begin
    if (x_wr) begin
      x_digit <= x_wr_data;
    end
    if (ctrl.clear) begin
      sum   <= '0;
      carry <= '0;
    end else if (ctrl.advance) begin
      // Low digit moves down one cell, high digit stays as carry.
      sum   <= sum_in;
      carry <= total[PROD_W-1:DIGIT_W];
    end
  end

endmodule

`default_nettype wire

// ===== design/multiprecision_multiply_accumulate.sv =====
// Top level of the base-256 multiprecision multiply-accumulate, z = z + x * y.
//
//   channel  direction  handshake           payload
//   load     in         load_valid/stall    load_item_t: x, y, acc digit, load_last
//   res      out        res_valid/stall     result_item_t: digit, overflow, last
//   cfg      in         cfg_valid/ready     cfg_index, cfg_data (x_length, y_length)
//
// Sequence: load transactions are taken only while idle. After load_last the
// block runs a clear step, streams the low accumulator digits into the cell
// row, emits the n+m result digits one per step, and then forms the overflow
// flag; y and z walk digit-serially through the row of multiply cells.
// Reset: rst is synchronous; lengths return to 32, the load position to zero.
// Stalls: res_stall freezes the cell row once result digits flow; load_stall
// stays high from load_last until the last result digit sits in res_data.
`default_nettype none

module multiprecision_multiply_accumulate
  import mpmac_pkg::*;
#(
  parameter int MAX_X_DIGITS = 32,
  parameter int MAX_Y_DIGITS = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 load_valid,
  output logic                      load_stall,
  input  wire load_item_t           load_data,
  output logic                      res_valid,
  input  wire logic                 res_stall,
  output result_item_t              res_data,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [LEN_W-1:0]     cfg_data
);

  localparam int ACC_DEPTH = MAX_X_DIGITS + MAX_Y_DIGITS;
  localparam int NW  = $clog2(MAX_X_DIGITS + 1);
  localparam int MW  = $clog2(MAX_Y_DIGITS + 1);
  localparam int TW  = $clog2(ACC_DEPTH + 1);
  localparam int XAW = $clog2(MAX_X_DIGITS);
  localparam int YAW = $clog2(MAX_Y_DIGITS);
  localparam int ZAW = $clog2(ACC_DEPTH);
  localparam int JW  = $clog2(MAX_X_DIGITS + ACC_DEPTH + 1);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_CLEAR  = 2'd1;
  localparam logic [1:0] ST_RUN    = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  // Control state
  logic [1:0]       state;
  logic [POS_W-1:0] pos;
  logic [LEN_W-1:0] x_length;
  logic [LEN_W-1:0] y_length;
  logic [JW-1:0]    step;
  logic [JW-1:0]    step_next;

  // Payload
  logic [DIGIT_W-1:0] last_digit;
  logic [DIGIT_W-1:0] y_rd;
  logic [DIGIT_W-1:0] z_rd;
  logic [DIGIT_W-1:0] y_mem [MAX_Y_DIGITS];
  logic [DIGIT_W-1:0] z_mem [ACC_DEPTH];

  logic [NW-1:0] n_len;
  logic [MW-1:0] m_len;
  logic [TW-1:0] total;

  logic load_acc, x_wr, y_wr, z_wr_load;
  logic pre_phase, emit, out_free, advance, at_last;
  logic y_live, z_live, y_rd_live;
  logic res_load;
  logic [JW-1:0]      last_step;
  logic [JW-1:0]      out_idx;
  logic [JW-1:0]      y_idx;
  logic [YAW-1:0]     y_addr;
  logic [ZAW-1:0]     z_addr;
  logic               z_we;
  logic [ZAW-1:0]     z_wa;
  logic [DIGIT_W-1:0] z_wd;
  logic [DIGIT_W-1:0] mult_digit;
  logic [DIGIT_W-1:0] top_in;
  logic [DIGIT_W-1:0] digit;
  logic               overflow;

  cell_ctrl_t                      cell_ctrl;
  logic [DIGIT_W-1:0]              cell_sum [MAX_X_DIGITS];
  logic [MAX_X_DIGITS-1:0]         cell_nz;

  // Clamp the configured lengths into their legal ranges.
  always_comb begin
    priority if (x_length == '0) begin
      n_len = NW'(1);
    end else if (x_length > LEN_W'(MAX_X_DIGITS)) begin
      n_len = NW'(MAX_X_DIGITS);
    end else begin
      n_len = x_length[NW-1:0];
    end
    priority if (y_length == '0) begin
      m_len = MW'(1);
    end else if (y_length > LEN_W'(MAX_Y_DIGITS)) begin
      m_len = MW'(MAX_Y_DIGITS);
    end else begin
      m_len = y_length[MW-1:0];
    end
  end

  assign total = TW'(n_len) + TW'(m_len);

  assign cfg_ready  = 1'b1;
  assign load_stall = (state != ST_IDLE);
  assign load_acc   = load_valid && !load_stall;

  // Store each operand digit only below its own length.
  assign x_wr      = load_acc && (pos < POS_W'(n_len));
  assign y_wr      = load_acc && (pos < POS_W'(m_len));
  assign z_wr_load = load_acc && (pos < POS_W'(total));

  // Step sequencing: the first MAX_X_DIGITS steps only fill the row with z.
  assign pre_phase = (step < JW'(MAX_X_DIGITS));
  assign emit      = (state == ST_RUN) && !pre_phase;
  assign out_free  = !res_valid || !res_stall;
  assign advance   = (state == ST_RUN) && (pre_phase || out_free);
  assign last_step = JW'(MAX_X_DIGITS) + JW'(total) - JW'(1);
  assign at_last   = (step == last_step);
  assign out_idx   = step - JW'(MAX_X_DIGITS);

  // Load the result register with a middle digit, or with the held last digit.
  assign res_load = (advance && emit && !at_last) || ((state == ST_FINISH) && out_free);

  always_comb begin
    priority if (state == ST_CLEAR) begin
      step_next = '0;
    end else if (advance) begin
      step_next = step + JW'(1);
    end else begin
      step_next = step;
    end
  end

  // Address memories with the next step so read data lines up with the step.
  assign y_idx     = step_next - JW'(MAX_X_DIGITS);
  assign y_rd_live = (step_next >= JW'(MAX_X_DIGITS))
                  && (step_next < JW'(MAX_X_DIGITS) + JW'(m_len));
  assign y_addr    = y_rd_live ? y_idx[YAW-1:0] : '0;
  assign z_addr    = (step_next < JW'(total)) ? step_next[ZAW-1:0] : '0;

  assign y_live     = !pre_phase && (step < JW'(MAX_X_DIGITS) + JW'(m_len));
  assign z_live     = (step < JW'(total));
  assign mult_digit = y_live ? y_rd : '0;
  assign top_in     = z_live ? z_rd : '0;
  assign digit      = cell_sum[0];
  assign overflow   = |cell_nz;

  // Write back each result digit so a later short load sees it.
  assign z_we = z_wr_load || (advance && emit);
  assign z_wa = emit ? out_idx[ZAW-1:0] : pos[ZAW-1:0];
  assign z_wd = emit ? digit : load_data.acc_digit;

  always_ff @(posedge clk) begin
    if (y_wr) begin
      y_mem[pos[YAW-1:0]] <= load_data.y_digit;
    end
    y_rd <= y_mem[y_addr];
  end

  always_ff @(posedge clk) begin
    if (z_we) begin
      z_mem[z_wa] <= z_wd;
    end
    z_rd <= z_mem[z_addr];
  end

  assign cell_ctrl.clear      = (state == ST_CLEAR);
  assign cell_ctrl.advance    = advance;
  assign cell_ctrl.mult_digit = mult_digit;

  // Row of cells: cell 0 yields the result digit, the top cell takes z.
  for (genvar i = 0; i < MAX_X_DIGITS; i++) begin : g_cell
    logic [DIGIT_W-1:0] sum_in;

    if (i == MAX_X_DIGITS - 1) begin : g_top
      assign sum_in = top_in;
    end else begin : g_mid
      assign sum_in = cell_sum[i+1];
    end

    mpmac_cell u_cell (
      .clk       (clk),
      .ctrl      (cell_ctrl),
      .x_wr      (x_wr && (pos[XAW-1:0] == XAW'(i))),
      .x_wr_data (load_data.x_digit),
      .x_en      (NW'(i) < n_len),
      .sum_in    (sum_in),
      .sum_out   (cell_sum[i]),
      .nonzero   (cell_nz[i])
    );
  end

  // Sequencer, configuration and output handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      pos       <= '0;
      x_length  <= LEN_RESET;
      y_length  <= LEN_RESET;
      step      <= '0;
      res_valid <= 1'b0;
    end else begin
      step <= step_next;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_X_LENGTH: x_length <= cfg_data;
          REG_Y_LENGTH: y_length <= cfg_data;
        endcase
      end
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (res_valid && !res_stall) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (load_acc) begin
            if (load_data.load_last) begin
              pos   <= '0;
              state <= ST_CLEAR;
            end else if (pos != POS_MAX) begin
              pos <= pos + POS_W'(1);
            end
          end
        end
        ST_CLEAR: begin
          state <= ST_RUN;
        end
        ST_RUN: begin
          if (advance && emit && at_last) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Result register and held last digit
  always_ff @(posedge clk) begin
    if (advance && emit) begin
      if (at_last) begin
        last_digit <= digit;
      end else begin
        res_data.result_digit <= digit;
        res_data.overflow     <= 1'b0;
        res_data.result_last  <= 1'b0;
      end
    end else if ((state == ST_FINISH) && out_free) begin
      // The row now holds the carry beyond n+m digits.
      res_data.result_digit <= last_digit;
      res_data.overflow     <= overflow;
      res_data.result_last  <= 1'b1;
    end
  end

  // Overflow only rides on the final digit of a result.
  a_overflow_on_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_data.result_last |-> !res_data.overflow)
    else $error("overflow flag on a non-final result digit");

  // The step counter never runs past the final result digit.
  a_step_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) |-> (step <= last_step))
    else $error("step counter beyond last result digit");

  // A new multiply always starts streaming from step zero.
  a_run_starts_at_zero: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |=> (state == ST_RUN) && (step == '0))
    else $error("multiply did not start at step zero");

endmodule

`default_nettype wire
